@@ rtl/core/pptr_pkg.sv @@
// Package for the pointer packet cursor tracker.
// Holds the packet job type, the configuration type and the register indexes.
// No dependencies.
package pptr_pkg;

    localparam int POS_W       = 12;
    localparam int SENS_W      = 4;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int QUEUE_DEPTH = 2;
    localparam int OUT_DATA_W  = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_MAX_X       = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_Y       = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SENSITIVITY = 2'd2;

    localparam logic [POS_W-1:0]  RESET_MAX_X  = 12'd1023;
    localparam logic [POS_W-1:0]  RESET_MAX_Y  = 12'd767;
    localparam logic [SENS_W-1:0] RESET_SENS   = 4'd2;
    localparam logic [POS_W-1:0]  RESET_CUR_X  = 12'd320;
    localparam logic [POS_W-1:0]  RESET_CUR_Y  = 12'd240;

    localparam logic [2:0] BUTTON_MASK = 3'h7;

    localparam logic KIND_BUTTON = 1'b0;
    localparam logic KIND_MOVE   = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0]  max_x;
        logic [POS_W-1:0]  max_y;
        logic [SENS_W-1:0] sens;
    } cfg_t;

    // One finished packet: where the cursor ended and what has to be reported.
    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [2:0]       buttons;
        logic [2:0]       changed;
        logic             moved;
    } job_t;

endpackage

@@ rtl/core/pointer_packet_cursor_tracker.sv @@
// Top level of the pointer packet cursor tracker: configuration registers,
// front part, job queue and back part. Depends on pptr_pkg, pptr_front,
// pptr_queue and pptr_back.
//
//  channel   direction  handshake            contents
//  s_*       in         s_tvalid / s_tready  one device byte a word
//  m_*       out        m_tvalid / m_tready  one cursor event a word
//  cfg_*     in         cfg_we               max_x, max_y, sensitivity
//
// Bytes are taken one a cycle. The third byte of a packet is held back only
// while the two-entry job queue is full. A packet that changes nothing sends
// no word; otherwise each event is one word from the output register, so a
// packet sends up to four words; when the back part is idle, the first passes
// through the job queue, the pending register and the output register.
// Reset is asynchronous and active low; the cursor starts at 320, 240.
// A stall on the output side fills the queue before it reaches the input.
module pointer_packet_cursor_tracker #(
    parameter int COORD_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] data_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [11:0] pos_x, [23:12] pos_y, [25:24] button_index, [26] pressed, rest zero
    output logic [pptr_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tuser,   // [0] event_kind
    output logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [pptr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [pptr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import pptr_pkg::*;

    cfg_t cfg_reg;
    logic push, q_full, q_empty, pop;
    job_t push_job, pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_x <= RESET_MAX_X;
            cfg_reg.max_y <= RESET_MAX_Y;
            cfg_reg.sens  <= RESET_SENS;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MAX_X:       cfg_reg.max_x <= cfg_wdata[POS_W-1:0];
                REG_MAX_Y:       cfg_reg.max_y <= cfg_wdata[POS_W-1:0];
                REG_SENSITIVITY: cfg_reg.sens  <= cfg_wdata[SENS_W-1:0];
                default:         ;
            endcase
        end
    end

    pptr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    pptr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .pop_job  (pop_job)
    );

    pptr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_job    (pop_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ rtl/core/pptr_front.sv @@
// Front part of the cursor tracker: gathers device bytes into packets and
// works out the new cursor and button changes. Depends on pptr_pkg.
module pptr_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pptr_pkg::cfg_t                cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,
    output logic                          push,
    output pptr_pkg::job_t                push_job,
    input  logic                          q_full
);
    import pptr_pkg::*;

    // Largest coordinate the cursor width allows, capped at the field width.
    localparam logic [POS_W-1:0] CAP = (COORD_BITS >= POS_W) ? {POS_W{1'b1}}
                                     : POS_W'((1 << COORD_BITS) - 1);

    logic [1:0]       byte_pos_reg, byte_pos_next;
    logic [7:0]       flags_reg;
    logic [7:0]       dx_byte_reg;
    logic [POS_W-1:0] cur_x_reg, cur_x_next;
    logic [POS_W-1:0] cur_y_reg, cur_y_next;
    logic [2:0]       btn_reg, btn_next;

    logic              accept;
    logic              last_byte;
    logic [POS_W-1:0]  lim_x, lim_y;
    logic signed [4:0]  sens_s;
    logic signed [12:0] prod_x, prod_y;
    logic signed [14:0] nx, ny;
    logic [POS_W-1:0]  clamp_x, clamp_y;
    logic [2:0]        new_btn, changed;
    logic              moved;

    // Position three cannot arise but is handled like the last byte.
    assign last_byte = byte_pos_reg[1];
    assign s_tready  = !last_byte || !q_full;
    assign accept    = s_tvalid && s_tready;

    assign lim_x  = (cfg.max_x < CAP) ? cfg.max_x : CAP;
    assign lim_y  = (cfg.max_y < CAP) ? cfg.max_y : CAP;
    assign sens_s = $signed({1'b0, cfg.sens});
    assign prod_x = $signed(dx_byte_reg) * sens_s;
    assign prod_y = $signed(s_tdata) * sens_s;
    assign nx = $signed({3'b000, cur_x_reg}) + $signed({{2{prod_x[12]}}, prod_x});
    assign ny = $signed({3'b000, cur_y_reg}) - $signed({{2{prod_y[12]}}, prod_y});

    always_comb
    begin
        if (nx[14])
            clamp_x = '0;
        else if (nx[13:0] > {2'b00, lim_x})
            clamp_x = lim_x;
        else
            clamp_x = nx[POS_W-1:0];

        if (ny[14])
            clamp_y = '0;
        else if (ny[13:0] > {2'b00, lim_y})
            clamp_y = lim_y;
        else
            clamp_y = ny[POS_W-1:0];
    end

    assign new_btn = flags_reg[2:0] & BUTTON_MASK;
    assign changed = new_btn ^ btn_reg;
    assign moved   = (clamp_x != cur_x_reg) || (clamp_y != cur_y_reg);

    assign push             = accept && last_byte && ((changed != 3'b000) || moved);
    assign push_job.pos_x   = clamp_x;
    assign push_job.pos_y   = clamp_y;
    assign push_job.buttons = new_btn;
    assign push_job.changed = changed;
    assign push_job.moved   = moved;

    always_comb
    begin
        byte_pos_next = byte_pos_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        btn_next      = btn_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                byte_pos_next = 2'd0;
                cur_x_next    = clamp_x;
                cur_y_next    = clamp_y;
                btn_next      = new_btn;
            end
            else
            begin
                byte_pos_next = byte_pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg <= 2'd0;
            cur_x_reg    <= RESET_CUR_X;
            cur_y_reg    <= RESET_CUR_Y;
            btn_reg      <= 3'b000;
        end
        else
        begin
            byte_pos_reg <= byte_pos_next;
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            btn_reg      <= btn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !last_byte)
        begin
            if (byte_pos_reg[0])
                dx_byte_reg <= s_tdata;
            else
                flags_reg <= s_tdata;
        end
    end

endmodule

@@ rtl/core/pptr_queue.sv @@
// Short job queue between the front and back parts of the cursor tracker.
// Depends on pptr_pkg.
module pptr_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pptr_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output pptr_pkg::job_t pop_job
);
    import pptr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

@@ rtl/core/pptr_back.sv @@
// Back part of the cursor tracker: takes packet jobs from the queue and
// sends their events one word a cycle through an output register while
// m_tready does not stall it. Depends on pptr_pkg.
module pptr_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  pptr_pkg::job_t                 q_job,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pptr_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast
);
    import pptr_pkg::*;

    // Bits 0..2 are button events, bit 3 the move event.
    logic [3:0]      pend_reg, pend_next;
    job_t            job_reg;
    logic            out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic            out_user_reg, out_last_reg;

    logic            emit;
    logic [3:0]      low_bit, pend_after;
    logic [1:0]      btn_idx;
    logic            is_move, pressed_bit;
    logic            load;

    assign low_bit    = pend_reg & (~pend_reg + 4'd1);
    assign pend_after = pend_reg & ~low_bit;
    assign emit       = (pend_reg != 4'd0) && (!out_valid_reg || m_tready);
    assign is_move    = low_bit[3];

    always_comb
    begin
        case (low_bit)
            4'b0010: btn_idx = 2'd1;
            4'b0100: btn_idx = 2'd2;
            default: btn_idx = 2'd0;
        endcase
    end

    assign pressed_bit = is_move ? 1'b0 : job_reg.buttons[btn_idx];

    // A new job may be taken once the current one sends its final word.
    assign load = !q_empty && ((pend_reg == 4'd0) || (emit && (pend_after == 4'd0)));
    assign pop  = load;

    always_comb
    begin
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;
        if (emit)
        begin
            pend_next      = pend_after;
            out_valid_next = 1'b1;
        end
        if (load)
            pend_next = {q_job.moved, q_job.changed};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            job_reg <= q_job;
        if (emit)
        begin
            out_data_reg <= {{(OUT_DATA_W - 2 * POS_W - 3){1'b0}}, pressed_bit,
                             (is_move ? 2'd0 : btn_idx), job_reg.pos_y, job_reg.pos_x};
            out_user_reg <= is_move ? KIND_MOVE : KIND_BUTTON;
            out_last_reg <= (pend_after == 4'd0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ rtl/core/pptr_checker.sv @@
// Port-level checks on the event channel of the cursor tracker, and the
// bind that attaches them to the top level. Depends on pptr_pkg.
module pptr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pptr_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tuser,
    input logic                            m_tlast
);
    import pptr_pkg::*;

    // A stalled word holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("event word changed while stalled");

    // A move event carries no button and is always the final word of its packet.
    a_move: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_MOVE) |->
            (m_tdata[25:24] == 2'd0) && !m_tdata[26] && m_tlast)
        else $error("malformed move event");

    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[25:24] != 2'd3))
        else $error("button index out of range");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_DATA_W-1:27] == '0))
        else $error("padding bits set");

endmodule

bind pointer_packet_cursor_tracker pptr_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ tb/pointer_packet_cursor_tracker_tb.sv @@
// Self-checking testbench for the pointer packet cursor tracker.
// Drives device bytes and register writes, predicts every cursor event and
// checks it word by word; depends on pptr_pkg and pointer_packet_cursor_tracker.
`timescale 1ns / 1ps

module pointer_packet_cursor_tracker_tb;
    import pptr_pkg::*;

    localparam int COORD_BITS        = 12;
    localparam int IDLE_LIMIT        = 2000;
    localparam int SETTLE_CYCLES     = 32;
    localparam int PHASES            = 8;
    localparam int PACKETS_PER_PHASE = 14;
    localparam int PRESSURE_PACKETS  = 12;
    localparam int HOLD_OFF_CYCLES   = 300;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [1:0]       btn;
        logic             pressed;
        logic             last_flag;
    } cursor_event_t;

    class cursor_scoreboard;
        logic [POS_W-1:0]  max_x;
        logic [POS_W-1:0]  max_y;
        logic [SENS_W-1:0] sens;
        logic [1:0]        byte_pos;
        logic [7:0]        flag_byte;
        logic [7:0]        dx_byte;
        logic [POS_W-1:0]  cur_x;
        logic [POS_W-1:0]  cur_y;
        logic [2:0]        buttons;
        cursor_event_t     event_q[$];
        int                errors;
        int                events_checked;
        int                bytes_seen;

        function new();
            max_x          = RESET_MAX_X;
            max_y          = RESET_MAX_Y;
            sens           = RESET_SENS;
            byte_pos       = 2'd0;
            flag_byte      = 8'h00;
            dx_byte        = 8'h00;
            cur_x          = RESET_CUR_X;
            cur_y          = RESET_CUR_Y;
            buttons        = 3'b000;
            errors         = 0;
            events_checked = 0;
            bytes_seen     = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_MAX_X:       max_x = val[POS_W-1:0];
                REG_MAX_Y:       max_y = val[POS_W-1:0];
                REG_SENSITIVITY: sens  = val[SENS_W-1:0];
                default: ;
            endcase
        endfunction

        // The bound is the smaller of the register and the coordinate width.
        function logic [POS_W-1:0] clamp(int v, logic [POS_W-1:0] reg_max);
            int cap;
            int lim;
            cap = (1 << COORD_BITS) - 1;
            lim = (int'(reg_max) < cap) ? int'(reg_max) : cap;
            if (v < 0)
                return '0;
            if (v > lim)
                return lim[POS_W-1:0];
            return v[POS_W-1:0];
        endfunction

        function void track_byte(logic [7:0] b);
            int               dx;
            int               dy;
            int               n;
            int               k;
            logic [POS_W-1:0] old_x;
            logic [POS_W-1:0] old_y;
            logic [2:0]       new_btn;
            logic [2:0]       changed;
            logic             moved;
            bytes_seen++;
            if (byte_pos < 2'd2)
            begin
                if (byte_pos == 2'd0)
                    flag_byte = b;
                else
                    dx_byte = b;
                byte_pos++;
                return;
            end
            byte_pos = 2'd0;
            dx = int'(dx_byte) - (dx_byte[7] ? 256 : 0);
            dy = int'(b) - (b[7] ? 256 : 0);
            old_x = cur_x;
            old_y = cur_y;
            // Y grows downwards on screen, so a positive dy moves the cursor up.
            cur_x = clamp(int'(cur_x) + dx * int'(sens), max_x);
            cur_y = clamp(int'(cur_y) - dy * int'(sens), max_y);
            new_btn = flag_byte[2:0] & BUTTON_MASK;
            changed = new_btn ^ buttons;
            buttons = new_btn;
            moved = (cur_x != old_x) || (cur_y != old_y);
            n = $countones(changed) + int'(moved);
            k = 0;
            for (int i = 0; i < 3; i++)
            begin
                if (changed[i])
                begin
                    event_q.push_back('{KIND_BUTTON, cur_x, cur_y, 2'(i), new_btn[i],
                                        k == n - 1});
                    k++;
                end
            end
            if (moved)
                event_q.push_back('{KIND_MOVE, cur_x, cur_y, 2'd0, 1'b0, 1'b1});
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // m_tdata: [11:0] pos_x, [23:12] pos_y, [25:24] button_index, [26] pressed.
        function void check_event(logic kind, logic [OUT_DATA_W-1:0] data, logic lastf);
            cursor_event_t want;
            if (event_q.size() == 0)
            begin
                $error("unexpected event: tuser=%0d tdata=%h tlast=%0d", kind, data, lastf);
                errors++;
                return;
            end
            want = event_q.pop_front();
            events_checked++;
            compare_field("event_kind", want.kind, kind);
            compare_field("pos_x", want.x, data[11:0]);
            compare_field("pos_y", want.y, data[23:12]);
            compare_field("button_index", want.btn, data[25:24]);
            compare_field("pressed", want.pressed, data[26]);
            compare_field("tdata_pad", 0, data[OUT_DATA_W-1:27]);
            compare_field("last", want.last_flag, lastf);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    cursor_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_req;
    int hold_len;
    int settings_used;

    always #6 clk = ~clk;

    pointer_packet_cursor_tracker #(
        .COORD_BITS(COORD_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.track_byte(b);
    endtask

    task automatic send_packet(input logic [7:0] flags, input logic [7:0] dx,
                               input logic [7:0] dy);
        send_byte(flags);
        send_byte(dx);
        send_byte(dy);
    endtask

    // Packets without events leave nothing to wait for, so allow some spare
    // cycles for the block to finish them before touching the registers.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.event_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic configure(input logic [POS_W-1:0] mx, input logic [POS_W-1:0] my,
                             input logic [SENS_W-1:0] s);
        write_reg(REG_MAX_X, CFG_DATA_W'(mx));
        write_reg(REG_MAX_Y, CFG_DATA_W'(my));
        write_reg(REG_SENSITIVITY, CFG_DATA_W'(s));
        settings_used++;
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 69; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
        endcase
    endtask

    // Mostly small moves, with full-range and boundary deltas mixed in.
    function automatic logic [7:0] rand_delta();
        case ($urandom_range(3))
            0: return 8'($urandom_range(255));
            1, 2: return 8'($urandom_range(16) - 8);
            default:
            begin
                case ($urandom_range(4))
                    0:       return 8'h7F;
                    1:       return 8'h80;
                    2:       return 8'h00;
                    3:       return 8'h01;
                    default: return 8'hFF;
                endcase
            end
        endcase
    endfunction

    function automatic logic [POS_W-1:0] rand_max();
        case ($urandom_range(3))
            0:       return POS_W'($urandom_range(4095));
            1:       return POS_W'($urandom_range(63));
            2:       return {POS_W{1'b1}};
            default: return POS_W'($urandom_range(1023, 256));
        endcase
    endfunction

    initial
    begin
        rst_n          <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= 8'h00;
        m_tready       <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_addr       <= REG_MAX_X;
        cfg_wdata      <= '0;
        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        hold_len       = 0;
        settings_used  = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: quiet packet, all buttons at once with full deltas,
        // release with the flag's upper bits set, then buttons alone.
        send_packet(8'h00, 8'h00, 8'h00);
        send_packet(8'h07, 8'h7F, 8'h7F);
        send_packet(8'hF8, 8'h80, 8'h80);
        send_packet(8'hFD, 8'h00, 8'h00);
        drain();
        // A sensitivity of zero cannot move the cursor.
        configure(12'hFFF, 12'hFFF, 4'd0);
        send_packet(8'h05, 8'h7F, 8'h80);
        drain();
        // Lowered bounds pull the cursor in even with no movement.
        configure(12'd100, 12'd50, 4'd15);
        send_packet(8'h05, 8'h00, 8'h00);
        send_packet(8'h02, 8'h7F, 8'h80);
        drain();
        configure(12'd0, 12'd0, 4'd1);
        send_packet(8'h02, 8'h01, 8'hFF);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                configure(12'hFFF, 12'hFFF, 4'd15);
            else if (p == 1)
                configure(12'd0, 12'd0, 4'd1);
            else
                configure(rand_max(), rand_max(), SENS_W'($urandom_range(15, 1)));
            set_idle(p % 4);
            for (int i = 0; i < PACKETS_PER_PHASE; i++)
                send_packet(8'($urandom_range(255)), rand_delta(), rand_delta());
            drain();
        end

        // Hold the output off while bytes keep coming so the job queue fills.
        configure(12'd1023, 12'd767, 4'd3);
        set_idle(0);
        hold_len = HOLD_OFF_CYCLES;
        hold_req++;
        for (int i = 0; i < PRESSURE_PACKETS; i++)
            send_packet(8'($urandom_range(255)), rand_delta(), rand_delta());
        drain();

        $display("Covered %0d device bytes and %0d cursor events over %0d register settings,",
                 sb.bytes_seen, sb.events_checked, settings_used);
        $display("with idle and stall phases on both sides and a long output hold-off.");
        if (sb.errors == 0 && sb.event_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Output side: checks each accepted word and decides tready for the next cycle.
    initial
    begin
        int hold_cnt;
        int hold_seen;
        hold_cnt  = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_event(m_tuser, m_tdata, m_tlast);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_cnt  = hold_len;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule
